// ===== hdl/gradient_non_max_suppression_assert.svh =====
// Assertion macros used by the checker module.
`ifndef GRADIENT_NON_MAX_SUPPRESSION_ASSERT_SVH
`define GRADIENT_NON_MAX_SUPPRESSION_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define GNMS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define GNMS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/gnms_pkg.sv =====
package gnms_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int KERNEL_DIM     = 3;
    localparam int MAG_W          = 16;
    localparam int DIR_FRAC_BITS  = 8;
    localparam int DIR_W          = DIR_FRAC_BITS + 1;
    localparam int ADDR_W         = $clog2(MAX_WIDTH);
    localparam int COL_W          = 10;
    localparam int ROW_W          = 12;
    localparam int FW_W           = 11;
    localparam int FH_W           = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 40;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;
    localparam logic [FW_W-1:0] FW_MIN   = FW_W'(KERNEL_DIM);
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MIN   = FH_W'(KERNEL_DIM);
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);

    // Sector bounds at 1/8, 3/8, 5/8 and 7/8 of the direction range
    localparam int DIR_UNIT = 1 << (DIR_FRAC_BITS - 3);
    localparam logic [DIR_W-1:0] DIR_B1 = DIR_W'(1 * DIR_UNIT);
    localparam logic [DIR_W-1:0] DIR_B3 = DIR_W'(3 * DIR_UNIT);
    localparam logic [DIR_W-1:0] DIR_B5 = DIR_W'(5 * DIR_UNIT);
    localparam logic [DIR_W-1:0] DIR_B7 = DIR_W'(7 * DIR_UNIT);

    typedef enum logic [1:0] {
        SECT_HORZ  = 2'd0,
        SECT_D45   = 2'd1,
        SECT_VERT  = 2'd2,
        SECT_D135  = 2'd3
    } sector_t;

    // One column entry of the line stores, read or written as a group
    typedef struct packed {
        logic [MAG_W-1:0] upper_mag;
        logic [MAG_W-1:0] middle_mag;
        logic [DIR_W-1:0] middle_dir;
    } line_word_t;

    function automatic sector_t dir_sector(input logic [DIR_W-1:0] d);
        sector_t s;
        if (d < DIR_B1 || d >= DIR_B7) begin
            s = SECT_HORZ;
        end else if (d < DIR_B3) begin
            s = SECT_D45;
        end else if (d < DIR_B5) begin
            s = SECT_VERT;
        end else begin
            s = SECT_D135;
        end
        return s;
    endfunction

endpackage

// ===== hdl/gnms_line_store.sv =====
module gnms_line_store (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [gnms_pkg::ADDR_W-1:0] rd_addr,
    output gnms_pkg::line_word_t      rd_data,
    input  logic                      wr_en,
    input  logic [gnms_pkg::ADDR_W-1:0] wr_addr,
    input  gnms_pkg::line_word_t      wr_data
);
    import gnms_pkg::*;

    logic [MAG_W-1:0] upper_mem  [MAX_WIDTH];
    logic [MAG_W-1:0] middle_mem [MAX_WIDTH];
    logic [DIR_W-1:0] dir_mem    [MAX_WIDTH];

    line_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg.upper_mag  <= upper_mem[rd_addr];
            rd_data_reg.middle_mag <= middle_mem[rd_addr];
            rd_data_reg.middle_dir <= dir_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr]  <= wr_data.upper_mag;
            middle_mem[wr_addr] <= wr_data.middle_mag;
            dir_mem[wr_addr]    <= wr_data.middle_dir;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/gnms_window.sv =====
module gnms_window (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  gnms_pkg::line_word_t       line_rd,
    input  logic [gnms_pkg::MAG_W-1:0] new_mag,
    output logic [gnms_pkg::MAG_W-1:0] kept_mag
);
    import gnms_pkg::*;

    // rows: upper, middle, lower; columns: left, center, right
    logic [MAG_W-1:0] win_reg  [KERNEL_DIM][KERNEL_DIM];
    logic [MAG_W-1:0] win_next [KERNEL_DIM][KERNEL_DIM];
    logic [DIR_W-1:0] center_dir_reg;
    logic [MAG_W-1:0] side_a;
    logic [MAG_W-1:0] side_b;
    logic [MAG_W-1:0] center;

    always_comb begin
        for (int r = 0; r < KERNEL_DIM; r++) begin
            for (int c = 0; c < KERNEL_DIM - 1; c++) begin
                win_next[r][c] = win_reg[r][c+1];
            end
        end
        win_next[0][KERNEL_DIM-1] = line_rd.upper_mag;
        win_next[1][KERNEL_DIM-1] = line_rd.middle_mag;
        win_next[2][KERNEL_DIM-1] = new_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < KERNEL_DIM; r++) begin
                for (int c = 0; c < KERNEL_DIM; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
            center_dir_reg <= '0;
        end else if (advance) begin
            win_reg        <= win_next;
            center_dir_reg <= line_rd.middle_dir;
        end
    end

    // Pick the neighbor pair along the gradient of the center pixel
    always_comb begin
        center = win_next[1][1];
        case (dir_sector(center_dir_reg))
            SECT_HORZ: begin
                side_a = win_next[1][0];
                side_b = win_next[1][2];
            end
            SECT_D45: begin
                side_a = win_next[0][2];
                side_b = win_next[2][0];
            end
            SECT_VERT: begin
                side_a = win_next[0][1];
                side_b = win_next[2][1];
            end
            SECT_D135: begin
                side_a = win_next[0][0];
                side_b = win_next[2][2];
            end
            default: begin
                side_a = win_next[1][0];
                side_b = win_next[1][2];
            end
        endcase
        kept_mag = (center >= side_a && center >= side_b) ? center : '0;
    end

endmodule

// ===== hdl/gradient_non_max_suppression.sv =====
// Streaming 3x3 non-maximum suppression. Gradient pixels enter in raster
// order on the s_ stream, one transaction per pixel; for every pixel whose
// row and column are both at least 2, one result transaction leaves on the
// m_ stream for the interior pixel one row up and one column left: its
// coordinates and its magnitude, kept when it is at least both neighbors
// along its direction sector and zero otherwise. Border pixels produce no
// transaction. m_tlast marks the last interior pixel of a frame. The block
// takes one pixel per clock when the m_ side does not stall. An accepted
// pixel is loaded into the input register together with the registered
// line store read; when the input stage advances, the compare result is
// loaded into the result register and the window shifts by one column.
// frame_width (index 0) and frame_height (index 1) are written on the cfg_
// port while the stream is idle; values outside 3..1024 and 3..4096 are
// clamped. The line stores need no clearing pass after reset: stale entries
// are read only in the first two rows of a frame, which emit no result.
module gradient_non_max_suppression (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: gradient_magnitude [15:0], gradient_direction [24:16], zero pad
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gnms_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: pixel_row [11:0], pixel_column [21:12], kept_magnitude [37:22],
    // zero pad; m_tlast: frame_done
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gnms_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gnms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gnms_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gnms_pkg::*;

    // Configuration registers
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [FW_W-1:0] width_eff;
    logic [FH_W-1:0] height_eff;

    // Raster position of the next pixel
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             last_col;
    logic             last_row;
    logic             emit;

    // Input stage: pixel waiting for its line store data
    logic              a_valid_reg;
    logic [MAG_W-1:0]  a_mag_reg;
    logic [DIR_W-1:0]  a_dir_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic              a_emit_reg;
    logic              a_done_reg;
    logic [ROW_W-1:0]  a_row_reg;
    logic [COL_W-1:0]  a_col_reg;

    // Result stage
    logic              m_valid_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [MAG_W-1:0]  m_mag_reg;
    logic              m_done_reg;

    logic              s_accept;
    logic              advance;
    line_word_t        line_rd;
    line_word_t        line_wr;
    logic [MAG_W-1:0]  kept_mag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the frame size into the range the line stores support
    always_comb begin
        if (frame_width_reg < FW_MIN) begin
            width_eff = FW_MIN;
        end else if (frame_width_reg > FW_MAX) begin
            width_eff = FW_MAX;
        end else begin
            width_eff = frame_width_reg;
        end
        if (frame_height_reg < FH_MIN) begin
            height_eff = FH_MIN;
        end else if (frame_height_reg > FH_MAX) begin
            height_eff = FH_MAX;
        end else begin
            height_eff = frame_height_reg;
        end
    end

    // Advance the input stage whenever the result register is free or drains
    assign advance  = a_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Raster position bookkeeping, done at acceptance
    always_comb begin
        last_col = ({1'b0, col_reg} + FW_W'(1)) >= width_eff;
        last_row = ({1'b0, row_reg} + FH_W'(1)) >= height_eff;
        emit     = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Input stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_mag_reg  <= s_tdata[MAG_W-1:0];
            a_dir_reg  <= s_tdata[MAG_W +: DIR_W];
            a_addr_reg <= col_reg[ADDR_W-1:0];
            a_emit_reg <= emit;
            a_done_reg <= last_row && last_col;
            a_row_reg  <= row_reg - ROW_W'(1);
            a_col_reg  <= col_reg - COL_W'(1);
        end
    end

    // Shift the column down a row: upper takes the old middle, middle the pixel
    always_comb begin
        line_wr.upper_mag  = line_rd.middle_mag;
        line_wr.middle_mag = a_mag_reg;
        line_wr.middle_dir = a_dir_reg;
    end

    gnms_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (col_reg[ADDR_W-1:0]),
        .rd_data (line_rd),
        .wr_en   (advance),
        .wr_addr (a_addr_reg),
        .wr_data (line_wr)
    );

    gnms_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .line_rd  (line_rd),
        .new_mag  (a_mag_reg),
        .kept_mag (kept_mag)
    );

    // Result register: load an interior pixel, drop the valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= a_emit_reg;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && a_emit_reg) begin
            m_row_reg  <= a_row_reg;
            m_col_reg  <= a_col_reg;
            m_mag_reg  <= kept_mag;
            m_done_reg <= a_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_mag_reg, m_col_reg, m_row_reg});
    assign m_tlast  = m_done_reg;

endmodule

// ===== hdl/gnms_checker.sv =====
`include "gradient_non_max_suppression_assert.svh"

module gnms_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [gnms_pkg::S_TDATA_W-1:0]      s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [gnms_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic                                m_tlast,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [gnms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [gnms_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gnms_pkg::*;

    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;

    assign out_row = m_tdata[ROW_W-1:0];
    assign out_col = m_tdata[ROW_W +: COL_W];

    // A stalled result keeps its payload
    `GNMS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // No result leaves right after reset
    `GNMS_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // Only interior pixels are emitted
    `GNMS_ASSERT(a_interior, aclk, aresetn, m_tvalid |-> out_row != '0 && out_col != '0, "border pixel emitted")

    // A draining result stage never blocks the input side
    `GNMS_ASSERT(a_no_block, aclk, aresetn, m_tready |-> s_tready, "input stalled while output drains")

endmodule

bind gradient_non_max_suppression gnms_checker u_gnms_checker (.*);
